// ===== src/wrse_pkg.sv =====
// Package for the wasm relocation site extractor.
// Holds the parser phase codes, the front-to-back queue word and the result kinds.
package wrse_pkg;

   typedef enum logic [3:0] {
      PH_HEADER  = 4'd0,
      PH_ID      = 4'd1,
      PH_SIZE    = 4'd2,
      PH_SKIP    = 4'd3,
      PH_NAMELEN = 4'd4,
      PH_NAME    = 4'd5,
      PH_SECIDX  = 4'd6,
      PH_COUNT   = 4'd7,
      PH_ENTRY   = 4'd8
   } phase_type;

   localparam logic KIND_SITE = 1'b0;
   localparam logic KIND_END  = 1'b1;

   localparam logic [2:0] CSR_SYM   = 3'd0;
   localparam logic [2:0] CSR_LEN   = 3'd1;
   localparam logic [2:0] CSR_NLEN  = 3'd2;
   localparam logic [2:0] CSR_NLOW  = 3'd3;
   localparam logic [2:0] CSR_NHIGH = 3'd4;

   // One byte's outcome: an optional site and an optional end marker.
   typedef struct packed {
      logic        site;
      logic        last;
      logic [31:0] func_index;
      logic [31:0] instr_index;
   } event_type;

endpackage

// ===== src/wrse_front.sv =====
// Front part: accepts bytes, runs the section/LEB128 walk, emits byte events.
// Depends on wrse_pkg.
module wrse_front #(
   parameter int MAX_NAME_BYTES = 16,
   parameter int HEADER_BYTES   = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [7:0]           data_byte,
   input  logic                 last_byte,
   input  logic                 cfg_sym,
   input  logic [31:0]          cfg_len,
   input  logic [4:0]           cfg_nlen,
   input  logic [127:0]         cfg_name,
   output wrse_pkg::event_type  ev
);
   import wrse_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [31:0] pos_ff, pos_in;
   logic [32:0] send_ff, send_in;
   logic [63:0] leb_ff, leb_in;
   logic [6:0]  shift_ff, shift_in;
   logic        custom_ff, custom_in;
   logic [63:0] nleft_ff, nleft_in;
   logic        nmatch_ff, nmatch_in;
   logic [4:0]  nidx_ff, nidx_in;
   logic [63:0] eleft_ff, eleft_in;
   logic [1:0]  field_ff, field_in;
   logic [31:0] held_ff, held_in;
   logic        stop_ff, stop_in;

   logic [63:0] lv;
   logic [6:0]  lsh;
   logic        ldone, lfail;
   logic [32:0] p33, start33;
   logic [64:0] room;
   logic        site;
   logic [7:0]  want;
   phase_type   ph;

   always_comb begin
      phase_in = phase_ff; pos_in = pos_ff; send_in = send_ff; leb_in = leb_ff;
      shift_in = shift_ff; custom_in = custom_ff; nleft_in = nleft_ff;
      nmatch_in = nmatch_ff; nidx_in = nidx_ff; eleft_in = eleft_ff;
      field_in = field_ff; held_in = held_ff; stop_in = stop_ff;
      site = 1'b0;
      p33 = {1'b0, pos_ff};
      start33 = p33 + 33'd1;
      room = '0;
      want = cfg_name[{nidx_ff[3:0], 3'b000} +: 8];
      // shared LEB128 step
      lv = (shift_ff == 7'd0) ? 64'd0 : leb_ff;
      if (shift_ff < 7'd64) lv = lv | ({57'd0, data_byte[6:0]} << shift_ff);
      lsh = shift_ff + 7'd7;
      ldone = ~data_byte[7];
      lfail = data_byte[7] && (lsh >= 7'd70);
      ph = phase_ff;
      if (!stop_ff && pos_ff < cfg_len) begin
         if (ph == PH_HEADER && p33 >= 33'(HEADER_BYTES)) ph = PH_ID;
         if (ph != PH_HEADER && ph != PH_ID && ph != PH_SIZE && p33 >= send_ff) begin
            ph = PH_ID; shift_in = '0;
            lv = 64'({57'd0, data_byte[6:0]});
            lsh = 7'd7; lfail = 1'b0;
         end
         phase_in = ph;
         if (ph != PH_HEADER && ph != PH_ID && ph != PH_SKIP && ph != PH_NAME) begin
            leb_in = lv;
            shift_in = (ldone || lfail) ? 7'd0 : lsh;
         end
         unique case (ph)
            PH_HEADER: ;
            PH_ID: begin
               custom_in = (data_byte == 8'd0); shift_in = '0; phase_in = PH_SIZE;
            end
            PH_SIZE: begin
               room = 65'({1'b0, cfg_len}) - 65'(start33);
               if (lfail) stop_in = 1'b1;
               else if (ldone) begin
                  if ({1'b0, lv} > room) stop_in = 1'b1;
                  else begin
                     send_in = start33 + lv[32:0];
                     phase_in = custom_ff ? PH_NAMELEN : PH_SKIP;
                  end
               end
            end
            PH_NAMELEN: begin
               room = 65'(send_ff) - 65'(start33);
               if (lfail) phase_in = PH_SKIP;
               else if (ldone) begin
                  if ({1'b0, lv} > room) phase_in = PH_SKIP;
                  else begin
                     nleft_in = lv; nmatch_in = (lv == 64'(cfg_nlen)); nidx_in = '0;
                     if (lv == 64'd0)
                        phase_in = (lv == 64'(cfg_nlen)) ? PH_SECIDX : PH_SKIP;
                     else phase_in = PH_NAME;
                  end
               end
            end
            PH_NAME: begin
               if (nidx_ff >= cfg_nlen || 32'(nidx_ff) >= 32'(MAX_NAME_BYTES) ||
                   nidx_ff >= 5'd16 || want != data_byte) nmatch_in = 1'b0;
               if (nidx_ff < 5'd31) nidx_in = nidx_ff + 5'd1;
               nleft_in = nleft_ff - 64'd1;
               if (nleft_ff == 64'd1) phase_in = nmatch_in ? PH_SECIDX : PH_SKIP;
            end
            PH_SECIDX: begin
               if (lfail) phase_in = PH_SKIP;
               else if (ldone) phase_in = PH_COUNT;
            end
            PH_COUNT: begin
               if (lfail) phase_in = PH_SKIP;
               else if (ldone) begin
                  eleft_in = lv; field_in = '0;
                  phase_in = (lv == 64'd0) ? PH_SKIP : PH_ENTRY;
               end
            end
            PH_ENTRY: begin
               if (lfail) phase_in = PH_SKIP;
               else if (ldone) begin
                  if (field_ff == 2'd0) begin
                     held_in = lv[31:0]; field_in = 2'd1;
                  end else if (cfg_sym && field_ff == 2'd1) field_in = 2'd2;
                  else if (cfg_sym && field_ff == 2'd2) field_in = 2'd3;
                  else begin
                     site = 1'b1; field_in = '0;
                     eleft_in = eleft_ff - 64'd1;
                     if (eleft_ff == 64'd1) phase_in = PH_SKIP;
                  end
               end
            end
            default: ;
         endcase
      end
      if (pos_ff != 32'hffff_ffff) pos_in = pos_ff + 32'd1;
   end

   assign ev.site        = site;
   assign ev.last        = last_byte;
   assign ev.func_index  = held_ff;
   assign ev.instr_index = lv[31:0];

   always_ff @(posedge clock) begin
      if (reset || (step && last_byte)) begin
         phase_ff <= PH_HEADER; pos_ff <= '0; send_ff <= '0; leb_ff <= '0;
         shift_ff <= '0; custom_ff <= 1'b0; nleft_ff <= '0; nmatch_ff <= 1'b1;
         nidx_ff <= '0; eleft_ff <= '0; field_ff <= '0; held_ff <= '0;
         stop_ff <= 1'b0;
      end else if (step) begin
         phase_ff <= phase_in; pos_ff <= pos_in; send_ff <= send_in; leb_ff <= leb_in;
         shift_ff <= shift_in; custom_ff <= custom_in; nleft_ff <= nleft_in;
         nmatch_ff <= nmatch_in; nidx_ff <= nidx_in; eleft_ff <= eleft_in;
         field_ff <= field_in; held_ff <= held_in; stop_ff <= stop_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      step && last_byte |=> phase_ff == PH_HEADER && pos_ff == 32'd0)
      else $error("state not cleared after last byte");
   assert property (@(posedge clock) disable iff (reset)
      stop_ff && step && !last_byte |=> stop_ff)
      else $error("stopped walk resumed");
   assert property (@(posedge clock) disable iff (reset)
      site |-> phase_ff == PH_ENTRY || phase_in == PH_SKIP)
      else $error("site outside entry phase");
endmodule

// ===== src/wrse_back.sv =====
// Back part: event queue whose head event is expanded into results.
// Depends on wrse_pkg.
module wrse_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 ev_push,
   input  wrse_pkg::event_type  ev,
   output logic                 full,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [31:0]          rsp_func_index,
   output logic [31:0]          rsp_instr_index,
   output logic                 rsp_record_kind,
   output logic                 rsp_last_of_run
);
   import wrse_pkg::*;

   event_type  q_ff [4];
   logic [1:0] wp_ff, rp_ff;
   logic [2:0] cnt_ff;
   logic       half_ff;     // site of head event already delivered
   event_type  head;
   logic       nonempty, pop, take, useful;

   assign head     = q_ff[rp_ff];
   assign nonempty = cnt_ff != 3'd0;
   assign useful   = ev.site || ev.last;
   assign take     = ev_push && useful;
   assign full     = cnt_ff == 3'd4;
   assign rsp_valid = nonempty;
   // head shows the site first, then the end marker
   assign rsp_record_kind = (head.site && !half_ff) ? KIND_SITE : KIND_END;
   assign rsp_func_index  = (rsp_record_kind == KIND_SITE) ? head.func_index : 32'd0;
   assign rsp_instr_index = (rsp_record_kind == KIND_SITE) ? head.instr_index : 32'd0;
   assign rsp_last_of_run = (rsp_record_kind == KIND_END) || !head.last;
   assign pop = nonempty && !rsp_stall && rsp_last_of_run;

   always_ff @(posedge clock) begin
      if (take) q_ff[wp_ff] <= ev;
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0; half_ff <= 1'b0;
      end else begin
         if (take) wp_ff <= wp_ff + 2'd1;
         if (pop) rp_ff <= rp_ff + 2'd1;
         cnt_ff <= cnt_ff + {2'd0, take} - {2'd0, pop};
         if (pop) half_ff <= 1'b0;
         else if (nonempty && !rsp_stall) half_ff <= 1'b1;
      end
   end

   assert property (@(posedge clock) disable iff (reset) cnt_ff <= 3'd4)
      else $error("queue overflow");
   assert property (@(posedge clock) disable iff (reset)
      half_ff |-> nonempty && head.site && head.last)
      else $error("split event state bad");
   assert property (@(posedge clock) disable iff (reset)
      !nonempty |=> !half_ff)
      else $error("half flag set on empty queue");
endmodule

// ===== src/wasm_reloc_site_extractor_core.sv =====
// Top level of the wasm relocation site extractor.
// Depends on wrse_pkg, wrse_front and wrse_back.
//
// Takes one module byte per transfer (one per cycle while the result side
// keeps up), skips the header, walks sections and, in the custom section
// whose name matches the CSR name, emits one result per relocation entry
// (function index, instruction index). The last byte adds an end marker.
// A 4-entry event queue decouples the front walk from the result port, so
// input stalls only when that queue fills. A byte giving a site and an end
// marker takes two result transfers. Configuration is to be written only
// while idle (the block does not enforce this); it takes effect on the next byte.
module wasm_reloc_site_extractor_core #(
   parameter int MAX_NAME_BYTES = 16,
   parameter int HEADER_BYTES   = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_func_index,
   output logic [31:0] rsp_instr_index,
   output logic        rsp_record_kind,
   output logic        rsp_last_of_run,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);
   import wrse_pkg::*;

   logic         sym_ff;
   logic [31:0]  len_ff;
   logic [4:0]   nlen_ff;
   logic [63:0]  nlow_ff, nhigh_ff;
   logic         full, step;
   event_type    ev;

   always_ff @(posedge clock) begin
      if (reset) begin
         sym_ff <= 1'b1; len_ff <= '0; nlen_ff <= '0; nlow_ff <= '0; nhigh_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_SYM:   sym_ff   <= csr_data[0];
            CSR_LEN:   len_ff   <= csr_data[31:0];
            CSR_NLEN:  nlen_ff  <= csr_data[4:0];
            CSR_NLOW:  nlow_ff  <= csr_data;
            CSR_NHIGH: nhigh_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign req_stall = full;
   assign step      = req_valid && !full;

   wrse_front #(.MAX_NAME_BYTES(MAX_NAME_BYTES), .HEADER_BYTES(HEADER_BYTES)) u_front (
      .clock(clock), .reset(reset), .step(step),
      .data_byte(req_data_byte), .last_byte(req_last_byte),
      .cfg_sym(sym_ff), .cfg_len(len_ff), .cfg_nlen(nlen_ff),
      .cfg_name({nhigh_ff, nlow_ff}), .ev(ev)
   );

   wrse_back u_back (
      .clock(clock), .reset(reset), .ev_push(step), .ev(ev), .full(full),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_func_index(rsp_func_index), .rsp_instr_index(rsp_instr_index),
      .rsp_record_kind(rsp_record_kind), .rsp_last_of_run(rsp_last_of_run)
   );

   assert property (@(posedge clock) disable iff (reset)
      step && req_last_byte |=> rsp_valid)
      else $error("end marker not queued");
endmodule

// ===== verif/tb_wasm_reloc_site_extractor_core.sv =====
// Testbench for wasm_reloc_site_extractor_core: streams wasm modules byte by byte and
// checks every relocation site and end marker against a behavioral predictor.
// Depends on wrse_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_wasm_reloc_site_extractor_core;
   import wrse_pkg::*;

   localparam int MAX_NAME  = 16;
   localparam int HDR       = 8;
   localparam int WATCHDOG  = 20000;
   localparam int LONG_HOLD = 300;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_data_byte;
   logic        req_last_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_func_index;
   logic [31:0] rsp_instr_index;
   logic        rsp_record_kind;
   logic        rsp_last_of_run;
   logic        csr_write;
   logic [2:0]  csr_index;
   logic [63:0] csr_data;

   wasm_reloc_site_extractor_core i_dut (.*);

   typedef struct packed {
      logic [31:0] func_index;
      logic [31:0] instr_index;
      logic        kind;
      logic        last_of_run;
   } site_rec_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } byte_item_type;

   typedef enum int { LEB_MORE, LEB_DONE, LEB_FAIL } leb_res_type;

   // predictor configuration
   logic        cfg_sym;
   logic [31:0] cfg_len;
   logic [4:0]  cfg_nlen;
   logic [63:0] cfg_nlow, cfg_nhigh;

   // predictor state
   phase_type   ph;
   logic [31:0] pos;
   logic [63:0] sec_end;
   logic [63:0] leb_val;
   int unsigned leb_sh;
   logic        is_custom;
   logic [63:0] name_left;
   logic        name_ok;
   int unsigned name_idx;
   logic [63:0] ent_left;
   int unsigned ent_field;
   logic [31:0] held_func;
   logic        stopped;

   site_rec_type   sites_expected[$];
   byte_item_type  pending_bytes[$];
   int          mismatches = 0;
   int          sites_seen = 0, ends_seen = 0;
   logic        sender_hold;       // sender paused until drained
   int          recv_hold = 0;     // long receiver hold-off, in cycles
   int          hold_reqs = 0;     // hold-offs asked for by the sequence
   int          hold_served = 0;   // hold-offs started by the receiver
   logic        saw_full = 1'b0;   // input stalled during a hold-off
   logic        quiet;             // no random idling

   task automatic clear_walk();
      ph = PH_HEADER; pos = 0; sec_end = 0; leb_val = 0; leb_sh = 0;
      is_custom = 0; name_left = 0; name_ok = 1; name_idx = 0;
      ent_left = 0; ent_field = 0; held_func = 0; stopped = 0;
   endtask

   function automatic leb_res_type leb_push(logic [7:0] b);
      if (leb_sh == 0) leb_val = 0;
      if (leb_sh < 64) leb_val = leb_val | (64'(b[6:0]) << leb_sh);
      leb_sh += 7;
      if (!b[7]) begin
         leb_sh = 0;
         return LEB_DONE;
      end
      if (leb_sh >= 70) begin
         leb_sh = 0;
         return LEB_FAIL;
      end
      return LEB_MORE;
   endfunction

   function automatic logic [7:0] want_byte(int unsigned i);
      logic [63:0] w;
      w = (i < 8) ? cfg_nlow : cfg_nhigh;
      return w[8*(i%8) +: 8];
   endfunction

   // walks one byte; returns 1 when an entry completes
   function automatic logic walk(logic [7:0] b, logic [63:0] p);
      leb_res_type r;
      logic [63:0] st;
      if (ph == PH_HEADER) begin
         if (p < HDR) return 0;
         ph = PH_ID;
      end
      if (ph != PH_ID && ph != PH_SIZE && p >= sec_end) begin
         ph = PH_ID;
         leb_sh = 0;
      end
      case (ph)
         PH_ID: begin
            is_custom = (b == 0);
            leb_sh = 0;
            ph = PH_SIZE;
         end
         PH_SIZE: begin
            r = leb_push(b);
            if (r == LEB_FAIL) stopped = 1;
            else if (r == LEB_DONE) begin
               st = p + 1;
               if (leb_val > 64'(cfg_len) - st) stopped = 1;
               else begin
                  sec_end = st + leb_val;
                  ph = is_custom ? PH_NAMELEN : PH_SKIP;
               end
            end
         end
         PH_NAMELEN: begin
            r = leb_push(b);
            if (r == LEB_FAIL) ph = PH_SKIP;
            else if (r == LEB_DONE) begin
               if (leb_val > sec_end - (p + 1)) ph = PH_SKIP;
               else begin
                  name_left = leb_val;
                  name_ok = (leb_val == 64'(cfg_nlen));
                  name_idx = 0;
                  if (name_left == 0) ph = name_ok ? PH_SECIDX : PH_SKIP;
                  else ph = PH_NAME;
               end
            end
         end
         PH_NAME: begin
            if (name_idx >= cfg_nlen || name_idx >= MAX_NAME || want_byte(name_idx) != b)
               name_ok = 0;
            if (name_idx < 31) name_idx++;
            name_left--;
            if (name_left == 0) ph = name_ok ? PH_SECIDX : PH_SKIP;
         end
         PH_SECIDX: begin
            r = leb_push(b);
            if (r == LEB_FAIL) ph = PH_SKIP;
            else if (r == LEB_DONE) ph = PH_COUNT;
         end
         PH_COUNT: begin
            r = leb_push(b);
            if (r == LEB_FAIL) ph = PH_SKIP;
            else if (r == LEB_DONE) begin
               ent_left = leb_val;
               ent_field = 0;
               ph = (ent_left == 0) ? PH_SKIP : PH_ENTRY;
            end
         end
         PH_ENTRY: begin
            r = leb_push(b);
            if (r == LEB_FAIL) begin
               ph = PH_SKIP;
               return 0;
            end
            if (r == LEB_MORE) return 0;
            if (ent_field == 0) begin
               held_func = leb_val[31:0];
               ent_field = 1;
               return 0;
            end
            // with symbol and addend, fields 1 and 2 are passed over and field 3 emits
            if (cfg_sym && ent_field != 3) begin
               ent_field = (ent_field + 1) % 4;
               return 0;
            end
            ent_field = 0;
            ent_left--;
            if (ent_left == 0) ph = PH_SKIP;
            return 1;
         end
         default: ;
      endcase
      return 0;
   endfunction

   task automatic predict_byte(byte_item_type it);
      site_rec_type s;
      if (!stopped && pos < cfg_len) begin
         if (walk(it.data, 64'(pos))) begin
            s.func_index = held_func;
            s.instr_index = leb_val[31:0];
            s.kind = KIND_SITE;
            s.last_of_run = !it.last;
            sites_expected.insert(sites_expected.size(), s);
         end
      end
      if (pos != 32'hffffffff) pos++;
      if (it.last) begin
         s = '{32'd0, 32'd0, KIND_END, 1'b1};
         sites_expected.insert(sites_expected.size(), s);
         clear_walk();
      end
   endtask

   task automatic report(string what, logic [63:0] got, logic [63:0] want);
      $display("ERROR @%0t %s: got %0h want %0h", $time, what, got, want);
      mismatches++;
   endtask

   // ---------------- stimulus building ----------------
   byte_item_type mod_bytes[$];

   task automatic put(logic [7:0] b);
      mod_bytes.insert(mod_bytes.size(), '{b, 1'b0});
   endtask

   // LEB encoding of v in at least n bytes (padded with continuation bytes)
   task automatic put_leb(logic [63:0] v, int n);
      int k;
      k = 0;
      do begin
         k++;
         put({(v >> 7) != 0 || k < n, v[6:0]});
         v = v >> 7;
      end while (v != 0 || k < n);
   endtask

   task automatic put_name(int len, logic [127:0] nm, logic corrupt);
      put_leb(64'(len), 1);
      for (int i = 0; i < len; i++)
         put((i < 16 ? nm[8*i +: 8] : 8'h41) ^ ((corrupt && i == len - 1) ? 8'h01 : 8'h00));
   endtask

   function automatic logic [63:0] rand_val();
      case ($urandom_range(0, 3))
         0: return 64'($urandom_range(0, 127));
         1: return 64'($urandom);
         2: return {$urandom, $urandom};
         default: return 64'($urandom_range(0, 20000));
      endcase
   endfunction

   // one module of 1 to 3 sections; sizes patched by building each body separately
   task automatic build_module(logic [127:0] nm, int nlen, logic sym, logic noisy);
      byte_item_type hdr[$];
      byte_item_type body[$];
      int nsec, cnt, sz;
      mod_bytes = {};
      for (int i = 0; i < HDR; i++) put(8'($urandom));
      hdr = mod_bytes;
      nsec = $urandom_range(1, 3);
      for (int s = 0; s < nsec; s++) begin
         mod_bytes = {};
         if ($urandom_range(0, 3) == 0) begin
            for (int i = 0; i < $urandom_range(0, 6); i++) put(8'($urandom));
            sz = mod_bytes.size(); body = mod_bytes; mod_bytes = hdr;
            put(8'($urandom_range(1, 12)));
         end else begin
            put_name(nlen, nm, noisy && $urandom_range(0, 3) == 0);
            put_leb(rand_val(), $urandom_range(1, 3));
            cnt = $urandom_range(0, 6);
            put_leb(64'(cnt + ((noisy && $urandom_range(0, 2) == 0) ? 2 : 0)), 1);
            for (int e = 0; e < cnt; e++) begin
               put_leb(rand_val(), $urandom_range(1, 2));
               put_leb(rand_val(), $urandom_range(1, 2));
               if (sym) begin
                  put_leb(rand_val(), 1);
                  put_leb(rand_val(), 1);
               end
            end
            if (noisy && $urandom_range(0, 4) == 0)
               for (int i = 0; i < 10; i++) put(8'hff);   // overlong LEB
            sz = mod_bytes.size(); body = mod_bytes; mod_bytes = hdr;
            put(8'h00);
         end
         put_leb(64'(sz + ((noisy && $urandom_range(0, 5) == 0) ? -1 : 0)), 1);
         foreach (body[i]) mod_bytes.insert(mod_bytes.size(), body[i]);
         hdr = mod_bytes;
      end
      if (noisy && $urandom_range(0, 3) == 0) begin
         for (int i = 0; i < 4; i++) put(8'($urandom));
      end
   endtask

   task automatic csr(logic [2:0] idx, logic [63:0] v);
      @(posedge clock);
      csr_write <= 1; csr_index <= idx; csr_data <= v;
      @(posedge clock);
      csr_write <= 0;
      case (idx)
         CSR_SYM:   cfg_sym = v[0];
         CSR_LEN:   cfg_len = v[31:0];
         CSR_NLEN:  cfg_nlen = v[4:0];
         CSR_NLOW:  cfg_nlow = v;
         CSR_NHIGH: cfg_nhigh = v;
         default: ;
      endcase
   endtask

   // waits until every queued byte has been accepted and every result came
   task automatic drain();
      while (pending_bytes.size() != 0 || sites_expected.size() != 0 || req_valid)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // sends one module with the given name config; length may be off by some bytes
   task automatic run_module(logic [127:0] nm, int nlen, logic sym, logic noisy, int len_adj);
      int len;
      build_module(nm, nlen, sym, noisy);
      len = mod_bytes.size() + len_adj;
      if (len < 0) len = 0;
      drain();
      csr(CSR_SYM, {63'($urandom), sym});
      csr(CSR_LEN, 64'(len));
      csr(CSR_NLEN, 64'(nlen));
      csr(CSR_NLOW, nm[63:0]);
      csr(CSR_NHIGH, nm[127:64]);
      mod_bytes[mod_bytes.size() - 1].last = 1;
      foreach (mod_bytes[i]) pending_bytes.insert(pending_bytes.size(), mod_bytes[i]);
   endtask

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   // ---------------- driver ----------------
   always @(posedge clock) begin
      byte_item_type it;
      if (reset) begin
         req_valid <= 0;
         req_data_byte <= '0;
         req_last_byte <= 0;
      end else if (!(req_valid && req_stall)) begin
         if (pending_bytes.size() != 0 && !sender_hold
             && (quiet || $urandom_range(0, 99) >= 24)) begin
            it = pending_bytes.pop_front();
            req_valid <= 1;
            req_data_byte <= it.data;
            req_last_byte <= it.last;
         end else begin
            req_valid <= 0;
         end
      end
   end

   // predictor runs on each accepted byte
   always @(posedge clock)
      if (reset) clear_walk();
      else if (req_valid && !req_stall)
         predict_byte('{req_data_byte, req_last_byte});

   // ---------------- receiver stall ----------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 0;
         recv_hold <= 0;
         hold_served <= 0;
         saw_full <= 0;
      end else begin
         if (hold_reqs != hold_served) begin
            hold_served <= hold_reqs;
            recv_hold <= LONG_HOLD;
            rsp_stall <= 1;
         end else if (recv_hold > 0) begin
            rsp_stall <= 1;
            recv_hold <= recv_hold - 1;
         end else rsp_stall <= quiet ? 1'b0 : ($urandom_range(0, 99) < 24);
         if (recv_hold > 0 && req_valid && req_stall) saw_full <= 1;
      end
   end

   // ---------------- monitor ----------------
   always @(posedge clock) begin
      site_rec_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (sites_expected.size() == 0) begin
            report("unexpected result", {rsp_func_index, rsp_instr_index}, 64'd0);
         end else begin
            w = sites_expected.pop_front();
            if (rsp_func_index != w.func_index)
               report("func_index", 64'(rsp_func_index), 64'(w.func_index));
            if (rsp_instr_index != w.instr_index)
               report("instr_index", 64'(rsp_instr_index), 64'(w.instr_index));
            if (rsp_record_kind != w.kind)
               report("record_kind", 64'(rsp_record_kind), 64'(w.kind));
            if (rsp_last_of_run != w.last_of_run)
               report("last_of_run", 64'(rsp_last_of_run), 64'(w.last_of_run));
            if (w.kind == KIND_END) ends_seen++; else sites_seen++;
         end
      end
   end

   // ---------------- watchdog ----------------
   int idle_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write)
         idle_cycles <= 0;
      else if (pending_bytes.size() != 0 || sites_expected.size() != 0 || req_valid) begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG) begin
            $display("Timeout: stuck for %0d cycles", idle_cycles);
            $display("Mismatches found");
            $finish;
         end
      end else idle_cycles <= 0;
   end

   // ---------------- sequence ----------------
   logic [127:0] nm;
   int nlen, total, quiet_from;
   logic paused;
   initial begin
      sender_hold = 0; quiet = 0; quiet_from = 0; paused = 0;
      csr_write = 0; csr_index = CSR_SYM; csr_data = 0;
      reset = 1;
      cfg_sym = 1; cfg_len = 0; cfg_nlen = 0; cfg_nlow = 0; cfg_nhigh = 0;
      repeat (2) @(posedge clock);
      reset <= 0;

      // directed: bytes with length zero, extremes of the data field
      pending_bytes.insert(pending_bytes.size(), '{8'h00, 1'b0});
      pending_bytes.insert(pending_bytes.size(), '{8'hff, 1'b1});
      total = 2;
      // empty name, symbol/addend off
      run_module('0, 0, 0, 0, 0);
      total += mod_bytes.size();
      // full 16-byte name, with symbols
      nm = {$urandom, $urandom, $urandom, $urandom};
      run_module(nm, 16, 1, 0, 0);
      total += mod_bytes.size();
      // oversized name length never matches
      run_module(nm, 17, 1, 0, 0);
      total += mod_bytes.size();
      // module length truncated: sections run past it
      run_module(nm, 4, 0, 0, -3);
      total += mod_bytes.size();
      // bytes past module_length
      run_module(nm, 3, 1, 0, -5);
      total += mod_bytes.size();
      drain();
      csr(CSR_LEN, 64'hffff_ffff);
      pending_bytes.insert(pending_bytes.size(), '{8'h01, 1'b1});
      total += 1;

      // random modules, a long quiet stretch in the middle
      while (total < 1850) begin
         if (total > 700 && quiet_from == 0) quiet_from = total;
         quiet = (quiet_from != 0) && (total < quiet_from + 300);
         nlen = $urandom_range(0, 3) == 0 ? $urandom_range(0, 18) : $urandom_range(1, 6);
         nm = {$urandom, $urandom, $urandom, $urandom};
         run_module(nm, nlen, $urandom_range(0, 1), $urandom_range(0, 3) == 0,
                    $urandom_range(0, 7) == 0 ? -int'($urandom_range(0, 4)) : 0);
         total += mod_bytes.size();
         if (total > 400 && !saw_full) hold_reqs++;   // fill the core up
         if (total > 1200 && !paused) begin
            paused = 1;
            sender_hold = 1;
            while (sites_expected.size() != 0) @(posedge clock);
            sender_hold = 0;
         end
      end
      drain();
      repeat (20) @(posedge clock);
      $display("Covered %0d relocation sites and %0d end markers over ~%0d bytes",
               sites_seen, ends_seen, total);
      if (mismatches == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end
endmodule
